FILE: design/pbs_pkg.sv
// Shared types, constants and helpers for the power button sequencer.
package pbs_pkg;

  // Debounce history depth, in ticks
  localparam int unsigned DEBOUNCE_SAMPLES = 8;

  // Stream and configuration widths
  localparam int unsigned S_TDATA_W   = 8;
  localparam int unsigned M_TDATA_W   = 8;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned TICK_W      = 16;
  localparam int unsigned MODE_CODE_W = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BOOT_TIMEOUT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SHUTDOWN_DELAY = CFG_INDEX_W'(1);

  // Configuration reset values
  localparam logic [TICK_W-1:0] BOOT_TIMEOUT_RST   = TICK_W'(200);
  localparam logic [TICK_W-1:0] SHUTDOWN_DELAY_RST = TICK_W'(100);

  // External mode codes
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_SLEEP  = MODE_CODE_W'(0);
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_IDLE   = MODE_CODE_W'(1);
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_BOOT   = MODE_CODE_W'(2);
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_ONLINE = MODE_CODE_W'(3);
  localparam logic [MODE_CODE_W-1:0] MODE_CODE_WAIT   = MODE_CODE_W'(4);

  // Sequencer state, one-hot
  typedef enum logic [4:0] {
    ST_SLEEP  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_BOOT   = 5'b00100,
    ST_ONLINE = 5'b01000,
    ST_WAIT   = 5'b10000
  } mode_t;

  // Configuration register set
  typedef struct packed {
    logic [TICK_W-1:0] boot_timeout;
    logic [TICK_W-1:0] shutdown_delay;
  } cfg_t;

  // Debouncer status for the tick being processed
  typedef struct packed {
    logic fall;        // raw falling edge against the newest stored sample
    logic level_next;  // debounced level after this tick
  } btn_status_t;

  // Sequencer result for one tick
  typedef struct packed {
    logic                   boost_enable;
    logic                   host_button;
    logic [MODE_CODE_W-1:0] mode_code;
  } seq_out_t;

  // Map internal state to the external mode code
  function automatic logic [MODE_CODE_W-1:0] mode_code_of(input mode_t m);
    logic [MODE_CODE_W-1:0] code;
    unique case (m)
      ST_SLEEP:  code = MODE_CODE_SLEEP;
      ST_IDLE:   code = MODE_CODE_IDLE;
      ST_BOOT:   code = MODE_CODE_BOOT;
      ST_ONLINE: code = MODE_CODE_ONLINE;
      ST_WAIT:   code = MODE_CODE_WAIT;
      default:   code = MODE_CODE_SLEEP;
    endcase
    return code;
  endfunction

endpackage

FILE: design/pbs_debounce.sv
// Button sample history, debounced level and raw falling-edge detect.
module pbs_debounce (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 raw_button,
  output pbs_pkg::btn_status_t status
);
  import pbs_pkg::*;

  logic [DEBOUNCE_SAMPLES-1:0] history;
  logic [DEBOUNCE_SAMPLES-1:0] history_next;
  logic                        level;

  // Shift in the new sample and settle the level on a full run of one value
  always_comb begin
    history_next      = {history[DEBOUNCE_SAMPLES-2:0], raw_button};
    status.fall       = history[0] & ~raw_button;
    status.level_next = level;
    if (&history_next) begin
      status.level_next = 1'b1;
    end else if (~|history_next) begin
      status.level_next = 1'b0;
    end
  end

  // Advance history and level once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '1;
      level   <= 1'b1;
    end else if (advance) begin
      history <= history_next;
      level   <= status.level_next;
    end
  end

endmodule

FILE: design/pbs_sequencer.sv
// Five-mode power sequencer with elapsed tick counter.
module pbs_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 ready_sync,
  input  pbs_pkg::cfg_t        cfg,
  input  pbs_pkg::btn_status_t btn,
  output pbs_pkg::seq_out_t    result
);
  import pbs_pkg::*;

  mode_t             mode;
  mode_t             mode_next;
  logic [TICK_W-1:0] elapsed;
  logic [TICK_W-1:0] elapsed_inc;
  logic [TICK_W-1:0] elapsed_next;
  logic              boost;
  logic              boost_next;
  logic              host_btn;
  logic              host_btn_next;

  // Saturating tick count
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + TICK_W'(1);

  // Decide the next mode and outputs for this tick
  always_comb begin
    mode_next     = mode;
    boost_next    = boost;
    host_btn_next = host_btn;
    unique case (mode)
      ST_SLEEP: begin
        boost_next    = 1'b0;
        host_btn_next = 1'b0;
        if (btn.fall) begin
          mode_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        host_btn_next = btn.level_next;
        if (!btn.level_next) begin
          mode_next = ST_BOOT;
        end
      end
      ST_BOOT: begin
        boost_next    = 1'b1;
        host_btn_next = btn.level_next;
        if (elapsed_inc > cfg.boot_timeout) begin
          mode_next = ST_SLEEP;
        end else if (ready_sync) begin
          mode_next = ST_ONLINE;
        end
      end
      ST_ONLINE: begin
        host_btn_next = btn.level_next;
        if (!ready_sync) begin
          mode_next = (cfg.shutdown_delay == '0) ? ST_SLEEP : ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (elapsed_inc >= cfg.shutdown_delay) begin
          mode_next = ST_SLEEP;
        end
      end
      default: begin
        mode_next = ST_SLEEP;
      end
    endcase
    // Drop the rail and host line at once on entering sleep
    if (mode_next == ST_SLEEP && mode != ST_SLEEP) begin
      boost_next    = 1'b0;
      host_btn_next = 1'b0;
    end
    elapsed_next = (mode_next != mode) ? '0 : elapsed_inc;
  end

  assign result.boost_enable = boost_next;
  assign result.host_button  = host_btn_next;
  assign result.mode_code    = mode_code_of(mode_next);

  // Commit state once per processed tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= ST_SLEEP;
      elapsed  <= '0;
      boost    <= 1'b0;
      host_btn <= 1'b0;
    end else if (advance) begin
      mode     <= mode_next;
      elapsed  <= elapsed_next;
      boost    <= boost_next;
      host_btn <= host_btn_next;
    end
  end

endmodule

FILE: design/power_button_sequencer.sv
// Top level: tick input register, debouncer, sequencer and result register.
// Path: a tick transfer passes through the input register, then the result
// register; while m_tready stalls the result, a filled input register waits.
// Throughput: one tick per cycle given m_tready; the two-stage stall chain is the only limit.
// Reset (rst, synchronous): mode sleep, history all ones, level released,
// boot_timeout 200, shutdown_delay 100, both register stages empty.
module power_button_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  // Tick input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [pbs_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] raw_button, [1] raw_ready
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [pbs_pkg::M_TDATA_W-1:0]   m_tdata,   // [0] boost_enable, [1] host_button,
                                                     // [4:2] mode_code, [5] button_level
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pbs_pkg::*;

  cfg_t        cfg;
  logic        in_valid;
  logic        in_button;
  logic        in_ready;
  logic        out_valid;
  logic [M_TDATA_W-1:0] out_data;
  logic        advance;
  logic        process;
  btn_status_t btn;
  seq_out_t    seq;

  // Stage handshake
  assign advance   = !out_valid || m_tready;
  assign process   = advance && in_valid;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_timeout   <= BOOT_TIMEOUT_RST;
      cfg.shutdown_delay <= SHUTDOWN_DELAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOOT_TIMEOUT:   cfg.boot_timeout   <= cfg_data;
        REG_SHUTDOWN_DELAY: cfg.shutdown_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_button <= s_tdata[0];
      in_ready  <= s_tdata[1];
    end
  end

  pbs_debounce u_debounce (
    .clk        (clk),
    .rst        (rst),
    .advance    (process),
    .raw_button (in_button),
    .status     (btn)
  );

  pbs_sequencer u_sequencer (
    .clk        (clk),
    .rst        (rst),
    .advance    (process),
    .ready_sync (in_ready),
    .cfg        (cfg),
    .btn        (btn),
    .result     (seq)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_data <= {2'b00, btn.level_next, seq.mode_code, seq.host_button, seq.boost_enable};
    end
  end

endmodule

FILE: design/pbs_checker.sv
// Port-level checks for the power button sequencer, bound to the top level.
module pbs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pbs_pkg::M_TDATA_W-1:0]   m_tdata
);
  import pbs_pkg::*;

  logic [MODE_CODE_W-1:0] mode_code;
  logic                   boost;
  logic                   host_btn;
  logic                   level;

  assign boost     = m_tdata[0];
  assign host_btn  = m_tdata[1];
  assign mode_code = m_tdata[4:2];
  assign level     = m_tdata[5];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Sleep keeps the rail and host line low
  a_sleep_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && mode_code == MODE_CODE_SLEEP |-> !boost && !host_btn)
    else $error("boost or host button active in sleep");

  // Online and shutdown wait keep the booster driven
  a_boot_boost: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (mode_code == MODE_CODE_ONLINE || mode_code == MODE_CODE_WAIT) |-> boost)
    else $error("boost off while powered");

  // Host line follows the debounced level in boot and online
  a_host_follow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (mode_code == MODE_CODE_BOOT || mode_code == MODE_CODE_ONLINE)
    |-> host_btn == level)
    else $error("host button does not follow debounced level");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind power_button_sequencer pbs_checker u_pbs_checker (
  .clk       (clk),
  .rst       (rst),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
